FILE: rtl/triangle_wave_channel_defines.svh
// ----------------------------------------------------------------------------
// Triangle wave channel assertion macros
// Clocked assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_WAVE_CHANNEL_DEFINES_SVH
`define TRIANGLE_WAVE_CHANNEL_DEFINES_SVH

`ifndef SYNTHESIS
// checked only outside reset
`define TWC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define TWC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define TWC_ASSERT(label, prop, msg)
`define TWC_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

FILE: rtl/twc_pkg.sv
// ----------------------------------------------------------------------------
// twc_pkg
// Shared types, event codes and lookup tables of the triangle wave channel.
// ----------------------------------------------------------------------------
`default_nettype none

package twc_pkg;

    localparam int OP_W     = 3;
    localparam int OFFS_W   = 2;
    localparam int DATA_W   = 8;
    localparam int SAMPLE_W = 4;
    localparam int STEP_W   = 5;
    localparam int PERIOD_W = 11;
    localparam int LEN_W    = 8;
    localparam int LIN_W    = 7;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE      = 3'd0,
        OP_TIMER_TICK = 3'd1,
        OP_LINEAR_CLK = 3'd2,
        OP_LENGTH_CLK = 3'd3,
        OP_SET_ENABLE = 3'd4
    } t_op;

    typedef enum logic [OFFS_W-1:0] {
        REG_CONTROL   = 2'd0,
        REG_UNUSED    = 2'd1,
        REG_PERIOD_LO = 2'd2,
        REG_PERIOD_HI = 2'd3
    } t_reg;

    // one event as held in the input register
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [OFFS_W-1:0] reg_offset;
        logic [DATA_W-1:0] write_data;
        logic              enable_value;
    } t_event;

    // what the core reports back per processed event
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                length_active;
    } t_result;

    localparam logic [SAMPLE_W-1:0] RAMP_LEVELS [32] = '{
        4'd15, 4'd14, 4'd13, 4'd12, 4'd11, 4'd10, 4'd9,  4'd8,
        4'd7,  4'd6,  4'd5,  4'd4,  4'd3,  4'd2,  4'd1,  4'd0,
        4'd0,  4'd1,  4'd2,  4'd3,  4'd4,  4'd5,  4'd6,  4'd7,
        4'd8,  4'd9,  4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15
    };

    localparam logic [LEN_W-1:0] LENGTH_LOADS [32] = '{
        8'd10,  8'd254, 8'd20, 8'd2,  8'd40, 8'd4,  8'd80, 8'd6,
        8'd160, 8'd8,   8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
        8'd12,  8'd16,  8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
        8'd192, 8'd24,  8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
    };

endpackage

`default_nettype wire

FILE: rtl/triangle_wave_channel.sv
// ----------------------------------------------------------------------------
// triangle_wave_channel
// Triangle-wave sound channel: one event in, one sample result out.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+-----------------------------------
//  event   | in        | i_valid / o_stall  | i_operation, i_reg_offset,
//          |           |                    | i_write_data, i_enable_value
//  result  | out       | o_valid / i_stall  | o_sample, o_length_active
//
//  One event per cycle while the result side does not stall; an event passes
//  through the input register, then the result register, before its result
//  can be taken.
//  Channel state updates in the cycle the event moves into the result register.
//  Reset is synchronous, active low; all channel state clears to zero.
//  A stall on the result side backs up through the input register only
//  when both stages hold a transfer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "triangle_wave_channel_defines.svh"

module triangle_wave_channel (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // event channel
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [twc_pkg::OP_W-1:0]      i_operation,
    input  wire logic [twc_pkg::OFFS_W-1:0]    i_reg_offset,
    input  wire logic [twc_pkg::DATA_W-1:0]    i_write_data,
    input  wire logic                          i_enable_value,
    // result channel
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [twc_pkg::SAMPLE_W-1:0]       o_sample,
    output logic                               o_length_active
);
    import twc_pkg::*;

    // input register
    logic    r_in_valid;
    t_event  r_event;

    // result register
    logic    r_out_valid;
    t_result r_result;

    t_result core_result;
    logic    out_free;   // result register can take a new value this cycle
    logic    advance;    // event in the input register is processed now
    logic    in_take;    // new event transfer accepted

    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign in_take  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take || advance) begin
            r_in_valid <= in_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_event.op           <= i_operation;
            r_event.reg_offset   <= i_reg_offset;
            r_event.write_data   <= i_write_data;
            r_event.enable_value <= i_enable_value;
        end
    end

    // channel state lives here; it commits only when the event advances
    twc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_event  (r_event),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= core_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_sample        = r_result.sample;
    assign o_length_active = r_result.length_active;

    // a processed event always lands in the result register
    `TWC_ASSERT(a_advance_gives_result, advance |=> o_valid, "processed event lost")
    // back-pressure only when the result register is full and held
    `TWC_ASSERT(a_stall_cause, o_stall |-> (o_valid && i_stall), "spurious input stall")
    // reset leaves both stages empty
    `TWC_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> (!o_valid && !o_stall),
        "pipeline not empty after reset")

endmodule

`default_nettype wire

FILE: rtl/twc_core.sv
// ----------------------------------------------------------------------------
// twc_core
// Channel state: timer, ramp sequencer, linear and length counters.
// Applies one event per cycle when i_fire is high and returns the new sample.
// ----------------------------------------------------------------------------
`default_nettype none

module twc_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire twc_pkg::t_event  i_event,
    output twc_pkg::t_result      o_result
);
    import twc_pkg::*;

    logic                r_control_flag,        n_control_flag;
    logic                r_length_halt_clear,   n_length_halt_clear;
    logic [LIN_W-1:0]    r_linear_reload_value, n_linear_reload_value;
    logic [PERIOD_W-1:0] r_period_reload,       n_period_reload;
    logic [PERIOD_W-1:0] r_period_count,        n_period_count;
    logic [LEN_W-1:0]    r_length_count,        n_length_count;
    logic [LIN_W-1:0]    r_linear_count,        n_linear_count;
    logic                r_reload_pending,      n_reload_pending;
    logic [STEP_W-1:0]   r_step_index,          n_step_index;
    logic                r_channel_enabled,     n_channel_enabled;

    always_comb begin
        n_control_flag        = r_control_flag;
        n_length_halt_clear   = r_length_halt_clear;
        n_linear_reload_value = r_linear_reload_value;
        n_period_reload       = r_period_reload;
        n_period_count        = r_period_count;
        n_length_count        = r_length_count;
        n_linear_count        = r_linear_count;
        n_reload_pending      = r_reload_pending;
        n_step_index          = r_step_index;
        n_channel_enabled     = r_channel_enabled;

        case (i_event.op)
            OP_WRITE: begin
                case (i_event.reg_offset)
                    REG_CONTROL: begin
                        n_control_flag        = i_event.write_data[7];
                        n_length_halt_clear   = ~i_event.write_data[7];
                        n_linear_reload_value = i_event.write_data[LIN_W-1:0];
                    end
                    REG_PERIOD_LO: begin
                        n_period_reload = {r_period_reload[PERIOD_W-1:8],
                                           i_event.write_data};
                    end
                    REG_PERIOD_HI: begin
                        n_period_reload = {i_event.write_data[2:0],
                                           r_period_reload[7:0]};
                        // length only loads while the channel is on
                        if (r_channel_enabled) begin
                            n_length_count = LENGTH_LOADS[i_event.write_data[7:3]];
                        end
                        n_reload_pending = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            OP_TIMER_TICK: begin
                if (r_period_count != '0) begin
                    n_period_count = r_period_count - 1'b1;
                end else begin
                    n_period_count = r_period_reload;
                    if ((r_length_count != '0) && (r_linear_count != '0) &&
                        (r_period_reload >= PERIOD_W'(2))) begin
                        n_step_index = r_step_index + 1'b1;
                    end
                end
            end
            OP_LINEAR_CLK: begin
                if (r_reload_pending) begin
                    n_linear_count = r_linear_reload_value;
                end else if (r_linear_count != '0) begin
                    n_linear_count = r_linear_count - 1'b1;
                end
                if (!r_control_flag) begin
                    n_reload_pending = 1'b0;
                end
            end
            OP_LENGTH_CLK: begin
                if (r_length_halt_clear && (r_length_count != '0)) begin
                    n_length_count = r_length_count - 1'b1;
                end
            end
            OP_SET_ENABLE: begin
                n_channel_enabled = i_event.enable_value;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_control_flag        <= 1'b0;
            r_length_halt_clear   <= 1'b0;
            r_linear_reload_value <= '0;
            r_period_reload       <= '0;
            r_period_count        <= '0;
            r_length_count        <= '0;
            r_linear_count        <= '0;
            r_reload_pending      <= 1'b0;
            r_step_index          <= '0;
            r_channel_enabled     <= 1'b0;
        end else if (i_fire) begin
            r_control_flag        <= n_control_flag;
            r_length_halt_clear   <= n_length_halt_clear;
            r_linear_reload_value <= n_linear_reload_value;
            r_period_reload       <= n_period_reload;
            r_period_count        <= n_period_count;
            r_length_count        <= n_length_count;
            r_linear_count        <= n_linear_count;
            r_reload_pending      <= n_reload_pending;
            r_step_index          <= n_step_index;
            r_channel_enabled     <= n_channel_enabled;
        end
    end

    // result reflects the state after this event
    assign o_result.sample        = n_channel_enabled ? RAMP_LEVELS[n_step_index] : '0;
    assign o_result.length_active = (n_length_count != '0);

endmodule

`default_nettype wire

FILE: verif/triangle_wave_channel_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_wave_channel_tb
// Self-checking bench for the triangle wave channel. Register writes, timer
// ticks, linear and length clocks and enable changes go in. A scoreboard
// predicts the sample and length status of every transfer and checks each
// result in order. Both sides idle at random.
// ----------------------------------------------------------------------------

module triangle_wave_channel_tb;
    import twc_pkg::*;

    localparam int                ITEM_TARGET  = 1400;
    localparam int                IDLE_LIMIT   = 1000; // cycles without any transfer
    localparam int                TAIL_CYCLES  = 10;   // two-stage pipe, with margin
    localparam logic [OP_W-1:0]   OP_LAST_CODE = 3'd7; // codes above OP_SET_ENABLE do nothing
    localparam logic [DATA_W-1:0] CTRL_HALT    = 8'h80; // control bit: hold length, keep reload

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the channel state and a queue of
    // expected results, one per accepted event.
    // ------------------------------------------------------------------------
    class sample_scoreboard;
        logic [LEN_W-1:0]    length_loads [32] = '{
            8'd10,  8'd254, 8'd20, 8'd2,  8'd40, 8'd4,  8'd80, 8'd6,
            8'd160, 8'd8,   8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
            8'd12,  8'd16,  8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
            8'd192, 8'd24,  8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
        };
        bit                  halt_flag;
        bit                  length_run;
        logic [LIN_W-1:0]    linear_reload;
        logic [PERIOD_W-1:0] period;
        logic [PERIOD_W-1:0] timer;
        logic [LEN_W-1:0]    length_count;
        logic [LIN_W-1:0]    linear_count;
        bit                  reload_flag;
        logic [STEP_W-1:0]   step;
        bit                  enabled;
        t_result             expected_samples [$];
        int                  errors;

        function new();
            halt_flag     = 1'b0;
            length_run    = 1'b0;
            linear_reload = '0;
            period        = '0;
            timer         = '0;
            length_count  = '0;
            linear_count  = '0;
            reload_flag   = 1'b0;
            step          = '0;
            enabled       = 1'b0;
            errors        = 0;
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction

        // apply one accepted event and queue the result it must produce
        function void note_event(t_event ev);
            t_result r;
            case (ev.op)
                OP_WRITE: begin
                    case (t_reg'(ev.reg_offset))
                        REG_CONTROL: begin
                            halt_flag     = ev.write_data[7];
                            length_run    = !ev.write_data[7];
                            linear_reload = ev.write_data[LIN_W-1:0];
                        end
                        REG_PERIOD_LO: period[7:0] = ev.write_data;
                        REG_PERIOD_HI: begin
                            period[10:8] = ev.write_data[2:0];
                            // length only loads while enabled; reload flag always set
                            if (enabled)
                                length_count = length_loads[ev.write_data[7:3]];
                            reload_flag = 1'b1;
                        end
                        default: ;
                    endcase
                end
                OP_TIMER_TICK: begin
                    if (timer != 0) begin
                        timer = timer - 1'b1;
                    end else begin
                        timer = period;
                        // short periods keep the timer running but freeze the ramp
                        if (length_count != 0 && linear_count != 0 && period >= 2)
                            step = step + 1'b1;
                    end
                end
                OP_LINEAR_CLK: begin
                    if (reload_flag)
                        linear_count = linear_reload;
                    else if (linear_count != 0)
                        linear_count = linear_count - 1'b1;
                    if (!halt_flag)
                        reload_flag = 1'b0;
                end
                OP_LENGTH_CLK: begin
                    if (length_run && length_count != 0)
                        length_count = length_count - 1'b1;
                end
                OP_SET_ENABLE: enabled = ev.enable_value;
                default: ;
            endcase
            if (!enabled)
                r.sample = '0;
            else if (step < 16)
                r.sample = SAMPLE_W'(15 - step);
            else
                r.sample = SAMPLE_W'(step - 16);
            r.length_active = (length_count != 0);
            expected_samples.push_back(r);
        endfunction

        function void check_sample(t_result got);
            t_result want;
            if (expected_samples.size() == 0) begin
                $error("result with nothing expected: sample %0d length_active %0d",
                       got.sample, got.length_active);
                errors++;
                return;
            end
            want = expected_samples.pop_front();
            if (got.sample !== want.sample) begin
                $error("sample: expected %0d, actual %0d", want.sample, got.sample);
                errors++;
            end
            if (got.length_active !== want.length_active) begin
                $error("length_active: expected %0d, actual %0d",
                       want.length_active, got.length_active);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [OP_W-1:0]     i_operation;
    logic [OFFS_W-1:0]   i_reg_offset;
    logic [DATA_W-1:0]   i_write_data;
    logic                i_enable_value;
    logic                o_valid;
    logic                i_stall;
    logic [SAMPLE_W-1:0] o_sample;
    logic                o_length_active;

    triangle_wave_channel u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_reg_offset   (i_reg_offset),
        .i_write_data   (i_write_data),
        .i_enable_value (i_enable_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_sample       (o_sample),
        .o_length_active(o_length_active)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    sample_scoreboard sb = new();
    int               events_sent;
    bit               send_hurry; // sender runs back to back while set
    bit               recv_hurry; // receiver never stalls while set

    function automatic int draw_gap(bit hurry);
        return hurry ? 0 : $urandom_range(0, 9);
    endfunction

    // ------------------------------------------------------------------------
    // Event side. Valid drops only when a gap is drawn, so a back-to-back
    // transfer never sees valid lowered and raised in the same step.
    // ------------------------------------------------------------------------
    task automatic send_event(logic [OP_W-1:0] op, logic [OFFS_W-1:0] offs,
                              logic [DATA_W-1:0] data, logic en);
        int     gap;
        t_event ev;
        gap = draw_gap(send_hurry);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_operation    <= op;
        i_reg_offset   <= offs;
        i_write_data   <= data;
        i_enable_value <= en;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        ev.op           = op;
        ev.reg_offset   = offs;
        ev.write_data   = data;
        ev.enable_value = en;
        sb.note_event(ev);
        events_sent++;
    endtask

    // register write with the unused fields left random
    task automatic write_reg(t_reg r, logic [DATA_W-1:0] data);
        send_event(OP_WRITE, r, data, 1'($urandom));
    endtask

    task automatic send_op(t_op op);
        send_event(op, OFFS_W'($urandom), DATA_W'($urandom), 1'($urandom));
    endtask

    // hold off new events until the pipe has drained completely
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // one note: set up the registers, reload the linear counter, then play it
    task automatic play_note();
        int                 body_len;
        int                 pick;
        logic [DATA_W-1:0]  ctrl;
        logic [DATA_W-1:0]  lo;
        logic [2:0]         hi;
        if ($urandom_range(0, 1) == 0)
            send_event(OP_SET_ENABLE, OFFS_W'($urandom), DATA_W'($urandom),
                       $urandom_range(0, 7) != 0);
        ctrl = DATA_W'($urandom);
        if ($urandom_range(0, 2) == 0)
            ctrl[LIN_W-1:0] = LIN_W'($urandom_range(1, 4));
        write_reg(REG_CONTROL, ctrl);
        // short periods make the ramp move within a few ticks
        lo = ($urandom_range(0, 4) == 0) ? DATA_W'($urandom) : DATA_W'($urandom_range(0, 6));
        write_reg(REG_PERIOD_LO, lo);
        hi = ($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'd0;
        write_reg(REG_PERIOD_HI, {5'($urandom), hi});
        send_op(OP_LINEAR_CLK);
        body_len = $urandom_range(10, 40);
        repeat (body_len) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_op(OP_TIMER_TICK);
            else if (pick < 80)
                send_op(OP_LINEAR_CLK);
            else if (pick < 90)
                send_op(OP_LENGTH_CLK);
            else if (pick < 95)
                send_op(OP_SET_ENABLE);
            else
                send_op(OP_WRITE);
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_operation    = OP_WRITE;
        i_reg_offset   = REG_CONTROL;
        i_write_data   = '0;
        i_enable_value = 1'b0;
        events_sent    = 0;
        send_hurry     = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed part ---
        send_op(OP_TIMER_TICK);                       // state straight out of reset
        for (int c = OP_SET_ENABLE + 1; c <= OP_LAST_CODE; c++)
            send_event(OP_W'(c), OFFS_W'($urandom), DATA_W'($urandom), 1'($urandom));
        write_reg(REG_UNUSED, 8'hFF);
        write_reg(REG_PERIOD_HI, 8'hFF);              // length load while disabled
        send_op(OP_LENGTH_CLK);
        send_event(OP_SET_ENABLE, REG_CONTROL, 8'h00, 1'b1);
        write_reg(REG_CONTROL, 8'h7F);                // largest linear reload
        write_reg(REG_PERIOD_LO, 8'h00);
        write_reg(REG_PERIOD_HI, 8'h08);              // longest length
        send_op(OP_LINEAR_CLK);
        send_op(OP_TIMER_TICK);                       // period 0: ramp holds
        send_op(OP_TIMER_TICK);
        write_reg(REG_PERIOD_LO, 8'h01);
        send_op(OP_TIMER_TICK);                       // period 1: ramp holds
        write_reg(REG_PERIOD_LO, 8'h02);
        repeat (4) send_op(OP_TIMER_TICK);            // ramp moves
        write_reg(REG_CONTROL, CTRL_HALT);
        send_op(OP_LENGTH_CLK);                       // halted, no decrement
        send_event(OP_SET_ENABLE, REG_CONTROL, 8'hFF, 1'b0);
        send_op(OP_TIMER_TICK);                       // disabled: sample forced low
        write_reg(REG_PERIOD_HI, 8'hF8);              // no length load while disabled
        send_event(OP_SET_ENABLE, REG_PERIOD_HI, 8'h00, 1'b1);
        drain_results();

        // --- random part: mostly notes, some raw noise ---
        while (events_sent < ITEM_TARGET) begin
            send_hurry = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 4) != 0) begin
                play_note();
            end else begin
                repeat ($urandom_range(1, 6))
                    send_event(OP_W'($urandom), OFFS_W'($urandom),
                               DATA_W'($urandom), 1'($urandom));
            end
            if ($urandom_range(0, 15) == 0)
                drain_results();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("triangle_wave_channel regression: pass");
        else
            $display("triangle_wave_channel regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: random stall before each transfer, with stall-free runs
    // ------------------------------------------------------------------------
    initial begin
        int      gap;
        int      taken;
        t_result got;
        i_stall    = 1'b0;
        recv_hurry = 1'b0;
        taken      = 0;
        wait (i_rst_n);
        forever begin
            if (taken % 64 == 0)
                recv_hurry = ($urandom_range(0, 3) == 0);
            gap = draw_gap(recv_hurry);
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            got.sample        = o_sample;
            got.length_active = o_length_active;
            sb.check_sample(got);
            taken++;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long with no transfer on either side ends the run
    // ------------------------------------------------------------------------
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("triangle_wave_channel regression: fail");
                $finish;
            end
        end
    end

endmodule
